>>> hw/rtl/shn_pkg.sv
// Package for the smoothed noise heightmap core: grid geometry, field widths,
// operation and register codes and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package shn_pkg;

  // Grid geometry (torus)
  localparam int GRID_W = 64;
  localparam int GRID_H = 64;
  localparam int NCELLS = GRID_W * GRID_H;
  localparam int ADDR_W = $clog2(NCELLS);
  localparam int XW     = $clog2(GRID_W);
  localparam int YW     = $clog2(GRID_H);

  // Field widths
  localparam int OP_W    = 2;
  localparam int IDX_W   = 12;
  localparam int SMP_W   = 16;
  localparam int ACC_W   = 24;
  localparam int HGT_W   = 16;
  localparam int SCL_W   = 32;
  localparam int CIDX_W  = 3;
  localparam int CDAT_W  = 16;
  localparam int IN_TW   = 32;
  localparam int OUT_TW  = 24;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_NUM_PASSES = 3'd0,
    REG_FIRST_PASS = 3'd1,
    REG_LAST_PASS  = 3'd2,
    REG_MIN_HEIGHT = 3'd3,
    REG_MAX_HEIGHT = 3'd4
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_P0,
    S_WDIV,
    S_WSQRT,
    S_NB,
    S_SUM,
    S_MUL,
    S_UPD,
    S_SINIT,
    S_SDIV,
    S_SFIN,
    S_RD1,
    S_RD2
  } state_t;

endpackage

>>> hw/rtl/shn_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module shn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds when not read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/smoothed_noise_heightmap_core.sv
// Smoothed value-noise heightmap core: top level with its pass sequencer.
// Depends on shn_pkg and shn_ram.
`timescale 1ns / 1ps

// Usage.
// Input requests arrive on in_tvalid/in_tready/in_tdata: a load writes one noise
// sample into the grid, a run performs all smoothing passes, a read returns one
// normalised height on out_tvalid/out_tready/out_tdata. Register writes come on
// the cfg channel and are taken only while the core is idle; while a register
// request is offered, input requests are held off so the two never pass together.
// A read of the accumulator passes through S_RD1 and S_RD2; out_tvalid rises as
// the core returns to idle. The result sits in an output register, so the core
// takes the next request while it waits, and a following read stalls in S_RD2
// only if the last result is not yet taken.
// In a run, every later pass reads the eight neighbours of each cell one at a time
// through the single read port of the noise memory, plus a per-cell read, multiply
// and write-back. A write of min_height or max_height, and the end of a run, start
// a scale computation (a 32 step serial division) during which nothing is taken;
// with a zero magnitude the division is skipped and the scale is cleared.
// Reset (rst_n low, synchronous) restores the register defaults and clears the
// magnitude and scale; the memories hold no defined contents until written.

module smoothed_noise_heightmap_core (
  input  logic clk,
  input  logic rst_n,
  // in_tdata: op [1:0], cell_index [13:2], noise_sample [29:14], zero [31:30]
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [shn_pkg::IN_TW-1:0]    in_tdata,
  // out_tdata: height [15:0], flat_map [16], zero [23:17]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [shn_pkg::OUT_TW-1:0]   out_tdata,
  // Register write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [shn_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [shn_pkg::CDAT_W-1:0]   cfg_data
);

  import shn_pkg::*;

  // Register file
  logic [4:0]              np_r;
  logic [3:0]              first_r;
  logic [3:0]              last_r;
  logic signed [15:0]      minh_r;
  logic signed [15:0]      maxh_r;
  logic [ACC_W-1:0]        maxmag_r;
  logic signed [SCL_W-1:0] scale_r;

  state_t state_r, state_nxt;

  // Request fields
  op_t                    in_op;
  logic [IDX_W-1:0]       in_idx;
  logic signed [SMP_W-1:0] in_smp;
  logic                   in_idx_ok;
  logic                   in_fire;

  assign in_op     = op_t'(in_tdata[1:0]);
  assign in_idx    = in_tdata[13:2];
  assign in_smp    = in_tdata[29:14];
  assign in_idx_ok = 32'(in_idx) < 32'(NCELLS);
  assign in_fire   = in_tvalid && in_tready;

  // Pass sequencing registers
  logic [4:0]          pass_r;
  logic [ADDR_W-1:0]   p0_cnt_r;
  logic                p0_wv_r;
  logic [ADDR_W-1:0]   p0_wa_r;
  logic [XW-1:0]       x_r;
  logic [YW-1:0]       y_r;
  logic [2:0]          nb_r;
  logic                rdv_r;
  logic signed [18:0]  sum_r;
  logic signed [15:0]  mean_r;
  logic signed [32:0]  prod_r;
  logic [15:0]         w_r;
  logic [5:0]          cnt_r;

  // Weight division and square root
  logic [36:0] wnum_r;
  logic [5:0]  wrem_r;
  logic [31:0] wq_r;
  logic [32:0] sv_r;
  logic [32:0] sres_r;
  logic [32:0] sbit_r;

  // Scale division
  logic [31:0] dv_r;
  logic [24:0] drem_r;
  logic [31:0] dq_r;
  logic        sneg_r;

  // Read path
  logic                rok_r;
  logic signed [55:0]  rprod_r;
  logic                out_valid_r;
  logic signed [15:0]  height_r;
  logic                flat_r;

  // Memory ports
  logic                ga_we, gb_we, acc_we, g_re, acc_re;
  logic [ADDR_W-1:0]   ga_wa, gb_wa, acc_wa, g_ra, acc_ra;
  logic [SMP_W-1:0]    ga_wd, gb_wd, ga_q, gb_q;
  logic [ACC_W-1:0]    acc_wd, acc_q;

  shn_ram #(.WIDTH(SMP_W), .DEPTH(NCELLS)) u_grid_a (
    .clk(clk), .we(ga_we), .waddr(ga_wa), .wdata(ga_wd),
    .re(g_re), .raddr(g_ra), .rdata(ga_q)
  );

  shn_ram #(.WIDTH(SMP_W), .DEPTH(NCELLS)) u_grid_b (
    .clk(clk), .we(gb_we), .waddr(gb_wa), .wdata(gb_wd),
    .re(g_re), .raddr(g_ra), .rdata(gb_q)
  );

  shn_ram #(.WIDTH(ACC_W), .DEPTH(NCELLS)) u_acc (
    .clk(clk), .we(acc_we), .waddr(acc_wa), .wdata(acc_wd),
    .re(acc_re), .raddr(acc_ra), .rdata(acc_q)
  );

  // Wrapped neighbour coordinates and addresses
  logic [XW-1:0]     xm, xp, nx;
  logic [YW-1:0]     ym, yp, ny;
  logic [ADDR_W-1:0] nb_addr, cell_addr;

  always_comb begin
    xm = (x_r == '0) ? XW'(GRID_W - 1) : x_r - 1'b1;
    xp = (x_r == XW'(GRID_W - 1)) ? '0 : x_r + 1'b1;
    ym = (y_r == '0) ? YW'(GRID_H - 1) : y_r - 1'b1;
    yp = (y_r == YW'(GRID_H - 1)) ? '0 : y_r + 1'b1;
    unique case (nb_r)
      3'd0:    begin nx = xm;  ny = ym;  end
      3'd1:    begin nx = x_r; ny = ym;  end
      3'd2:    begin nx = xp;  ny = ym;  end
      3'd3:    begin nx = xp;  ny = y_r; end
      3'd4:    begin nx = xp;  ny = yp;  end
      3'd5:    begin nx = x_r; ny = yp;  end
      3'd6:    begin nx = xm;  ny = yp;  end
      default: begin nx = xm;  ny = y_r; end
    endcase
    nb_addr   = ADDR_W'(32'(ny) * GRID_W + 32'(nx));
    cell_addr = ADDR_W'(32'(y_r) * GRID_W + 32'(x_r));
  end

  // Pass flags
  logic pass_used, pass_last, src_is_a;
  assign pass_used = (pass_r >= {1'b0, first_r}) && (pass_r <= {1'b0, last_r});
  assign pass_last = (pass_r == np_r - 5'd1);
  assign src_is_a  = pass_r[0];

  logic signed [SMP_W-1:0] src_q;
  assign src_q = src_is_a ? ga_q : gb_q;

  // Mean and accumulator update
  logic signed [18:0] sum_rnd;
  logic signed [15:0] mean_c;
  logic signed [16:0] addend;
  logic signed [32:0] prod_rnd;
  logic signed [24:0] acc_sum;
  logic signed [ACC_W-1:0] acc_sat, acc_new, acc_old;
  logic [ACC_W-1:0]   acc_mag;

  always_comb begin
    sum_rnd  = sum_r + 19'sd4;
    mean_c   = 16'(sum_rnd >>> 3);
    prod_rnd = prod_r + 33'sd32768;
    addend   = 17'(prod_rnd >>> 16);
    acc_old  = acc_q;
    acc_sum  = 25'(acc_old) + 25'(addend);
    if (acc_sum > 25'sd8388607) begin
      acc_sat = 24'sh7FFFFF;
    end else if (acc_sum < -25'sd8388608) begin
      acc_sat = 24'sh800000;
    end else begin
      acc_sat = acc_sum[23:0];
    end
    acc_new = pass_used ? acc_sat : acc_old;
    acc_mag = acc_new[ACC_W-1] ? ACC_W'(-acc_new) : ACC_W'(acc_new);
  end

  // Serial division and square root steps
  logic [5:0]  wr2;
  logic        wge;
  logic [32:0] s_try;
  logic        s_ge;
  logic [24:0] dr2;
  logic        dge;

  always_comb begin
    wr2   = {wrem_r[4:0], wnum_r[36]};
    wge   = wr2 >= {1'b0, np_r};
    s_try = sres_r + sbit_r;
    s_ge  = sv_r >= s_try;
    dr2   = {drem_r[23:0], dv_r[31]};
    dge   = dr2 >= {1'b0, maxmag_r};
  end

  // Scale set-up
  logic signed [16:0] hdiff;
  logic [16:0]        hdiff_abs;
  logic [31:0]        scl_dividend;

  always_comb begin
    hdiff        = 17'(maxh_r) - 17'(minh_r);
    hdiff_abs    = hdiff[16] ? 17'(-hdiff) : 17'(hdiff);
    scl_dividend = {1'b0, hdiff_abs[15:0], 15'd0} + 32'(maxmag_r >> 1);
  end

  // Read result
  logic signed [56:0] rd_t;
  logic signed [40:0] rd_h;
  logic signed [15:0] rd_sat;
  logic               out_free;

  always_comb begin
    rd_t = 57'(rprod_r) + (57'(17'(maxh_r) + 17'(minh_r)) <<< 15) + 57'sd32768;
    rd_h = 41'(rd_t >>> 16);
    if (rd_h > 41'sd32767) begin
      rd_sat = 16'sh7FFF;
    end else if (rd_h < -41'sd32768) begin
      rd_sat = 16'sh8000;
    end else begin
      rd_sat = rd_h[15:0];
    end
    out_free = !out_valid_r || out_tready;
  end

  // Next state, handshakes and memory controls
  always_comb begin
    state_nxt = state_r;
    in_tready = (state_r == S_IDLE) && !cfg_valid;
    cfg_ready = (state_r == S_IDLE);
    ga_we  = 1'b0; ga_wa  = cell_addr; ga_wd  = mean_r;
    gb_we  = 1'b0; gb_wa  = cell_addr; gb_wd  = mean_r;
    acc_we = 1'b0; acc_wa = cell_addr; acc_wd = acc_new;
    g_re   = 1'b0; g_ra   = nb_addr;
    acc_re = 1'b0; acc_ra = cell_addr;

    // Delayed accumulator write of the initial pass
    if (p0_wv_r) begin
      acc_we = 1'b1;
      acc_wa = p0_wa_r;
      acc_wd = (first_r == '0) ? ACC_W'(signed'(ga_q)) : '0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (cfg_valid && (cfg_index == REG_MIN_HEIGHT || cfg_index == REG_MAX_HEIGHT)) begin
          state_nxt = S_SINIT;
        end else if (in_fire) begin
          unique case (in_op)
            OP_LOAD: begin
              ga_we = in_idx_ok;
              ga_wa = ADDR_W'(in_idx);
              ga_wd = in_smp;
            end
            OP_RUN:  state_nxt = S_P0;
            OP_READ: begin
              acc_re    = 1'b1;
              acc_ra    = ADDR_W'(in_idx);
              state_nxt = S_RD1;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_P0: begin
        g_re = 1'b1;
        g_ra = p0_cnt_r;
        if (p0_cnt_r == ADDR_W'(NCELLS - 1)) begin
          state_nxt = (np_r > 5'd1) ? S_WDIV : S_SINIT;
        end
      end
      S_WDIV: begin
        if (cnt_r == 6'd37) begin
          state_nxt = S_WSQRT;
        end
      end
      S_WSQRT: begin
        if (sbit_r == '0) begin
          state_nxt = S_NB;
        end
      end
      S_NB: begin
        g_re   = 1'b1;
        acc_re = (nb_r == 3'd0);
        if (nb_r == 3'd7) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: state_nxt = S_MUL;
      S_MUL: state_nxt = S_UPD;
      S_UPD: begin
        ga_we  = !src_is_a;
        gb_we  = src_is_a;
        acc_we = pass_used;
        if (x_r == XW'(GRID_W - 1) && y_r == YW'(GRID_H - 1)) begin
          state_nxt = pass_last ? S_SINIT : S_WDIV;
        end else begin
          state_nxt = S_NB;
        end
      end
      S_SINIT: state_nxt = (maxmag_r == '0) ? S_IDLE : S_SDIV;
      S_SDIV: begin
        if (cnt_r == 6'd31) begin
          state_nxt = S_SFIN;
        end
      end
      S_SFIN: state_nxt = S_IDLE;
      S_RD1:  state_nxt = S_RD2;
      S_RD2: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      np_r        <= 5'd8;
      first_r     <= 4'd0;
      last_r      <= 4'd15;
      minh_r      <= 16'sd0;
      maxh_r      <= 16'sd1024;
      maxmag_r    <= '0;
      scale_r     <= '0;
      out_valid_r <= 1'b0;
      p0_wv_r     <= 1'b0;
      rdv_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p0_wv_r <= (state_r == S_P0);
      rdv_r   <= (state_r == S_NB);

      // Register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_NUM_PASSES: np_r    <= cfg_data[4:0];
          REG_FIRST_PASS: first_r <= cfg_data[3:0];
          REG_LAST_PASS:  last_r  <= cfg_data[3:0];
          REG_MIN_HEIGHT: minh_r  <= cfg_data;
          REG_MAX_HEIGHT: maxh_r  <= cfg_data;
          default: ;
        endcase
      end

      // Largest magnitude, cleared at the start of a run
      if (state_r == S_IDLE && in_fire && in_op == OP_RUN) begin
        maxmag_r <= '0;
      end else if (state_r == S_UPD && pass_last && acc_mag > maxmag_r) begin
        maxmag_r <= acc_mag;
      end

      // Scale factor
      if (state_r == S_SINIT && maxmag_r == '0) begin
        scale_r <= '0;
      end else if (state_r == S_SFIN) begin
        scale_r <= sneg_r ? SCL_W'(-dq_r) : SCL_W'(dq_r);
      end

      // Output register
      if (state_r == S_RD2 && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    p0_wa_r <= p0_cnt_r;
    if (rdv_r) begin
      sum_r <= sum_r + 19'(src_q);
    end

    unique case (state_r)
      S_IDLE: begin
        p0_cnt_r <= '0;
        rok_r    <= in_idx_ok;
        pass_r   <= 5'd1;
      end
      S_P0: begin
        p0_cnt_r <= p0_cnt_r + 1'b1;
        x_r      <= '0;
        y_r      <= '0;
        cnt_r    <= '0;
        wnum_r   <= {pass_r, 32'd0};
        wrem_r   <= '0;
      end
      S_WDIV: begin
        wnum_r <= {wnum_r[35:0], 1'b0};
        wrem_r <= wge ? wr2 - {1'b0, np_r} : wr2;
        wq_r   <= {wq_r[30:0], wge};
        cnt_r  <= cnt_r + 1'b1;
        sv_r   <= {1'b0, wq_r};
        sres_r <= '0;
        sbit_r <= 33'd1 << 30;
      end
      S_WSQRT: begin
        if (sbit_r != '0) begin
          if (s_ge) begin
            sv_r   <= sv_r - s_try;
            sres_r <= (sres_r >> 1) + sbit_r;
          end else begin
            sres_r <= sres_r >> 1;
          end
          sbit_r <= sbit_r >> 2;
        end
        w_r   <= sres_r[15:0];
        nb_r  <= '0;
        sum_r <= '0;
      end
      S_NB: nb_r <= nb_r + 1'b1;
      S_SUM: ;
      S_MUL: begin
        mean_r <= mean_c;
        prod_r <= mean_c * $signed({1'b0, w_r});
      end
      S_UPD: begin
        nb_r  <= '0;
        sum_r <= '0;
        if (x_r == XW'(GRID_W - 1)) begin
          x_r <= '0;
          if (y_r == YW'(GRID_H - 1)) begin
            y_r    <= '0;
            pass_r <= pass_r + 1'b1;
            cnt_r  <= '0;
            wnum_r <= {pass_r + 5'd1, 32'd0};
            wrem_r <= '0;
          end else begin
            y_r <= y_r + 1'b1;
          end
        end else begin
          x_r <= x_r + 1'b1;
        end
      end
      S_SINIT: begin
        dv_r   <= scl_dividend;
        drem_r <= '0;
        cnt_r  <= '0;
        sneg_r <= hdiff[16];
      end
      S_SDIV: begin
        dv_r   <= {dv_r[30:0], 1'b0};
        drem_r <= dge ? dr2 - {1'b0, maxmag_r} : dr2;
        dq_r   <= {dq_r[30:0], dge};
        cnt_r  <= cnt_r + 1'b1;
      end
      S_SFIN: ;
      S_RD1: begin
        rprod_r <= (rok_r ? $signed(acc_q) : 24'sd0) * scale_r;
      end
      S_RD2: begin
        if (out_free) begin
          height_r <= rd_sat;
          flat_r   <= (maxmag_r == '0);
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, flat_r, height_r};

endmodule
